// File: hdl/qrc_pkg.sv
// ----------------------------------------------------------------------------
// qrc_pkg: shared types and constants of the probed query result cache
// field widths, operation codes, default sizes and the controller/datapath
// command and status bundles
// ----------------------------------------------------------------------------
package qrc_pkg;

    // default table geometry (table size must be a power of two)
    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int PROBE_LIMIT_DEF = 4;

    // request and result field widths
    localparam int KEY_W  = 64;
    localparam int PAY_W  = 32;
    localparam int SLOT_W = 12;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture a new request
        logic probe;   // issue the next probe read
        logic finish;  // register the result, write the slot on insert
        logic clr;     // write one cleared entry of the clearing pass
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic chk_live;    // read data of a probe is waiting to be checked
        logic chk_hit;     // that probe ends the search (key match on lookup, free slot on insert)
        logic chk_last;    // that probe is the last one of the sequence
        logic issue_more;  // probes are left to issue
        logic clr_done;    // clearing pass is at its last entry
    } t_sts;

endpackage

// File: hdl/qrc_ctrl.sv
// ----------------------------------------------------------------------------
// qrc_ctrl: sequencer of the probed query result cache
// runs the clearing pass after reset and steps the probe reads of a request
// ----------------------------------------------------------------------------
module qrc_ctrl
    import qrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       finish;

    assign finish = i_sts.chk_live && (i_sts.chk_hit || i_sts.chk_last);

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.probe  = 1'b0;
        o_cmd.finish = 1'b0;
        o_cmd.clr    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.probe = i_sts.issue_more;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// File: hdl/qrc_datapath.sv
// ----------------------------------------------------------------------------
// qrc_datapath: slot memory, probe addressing and result registers
// one entry holds valid, key and handle; one read and one write per cycle
// ----------------------------------------------------------------------------
module qrc_datapath
    import qrc_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_operation,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [PAY_W-1:0]  i_payload,
    output logic              o_valid,
    output logic              o_hit,
    output logic [PAY_W-1:0]  o_found_payload,
    output logic [SLOT_W-1:0] o_slot_used,
    output logic              o_evicted
);

    localparam int ADDR_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(PROBE_LIMIT + 1);
    localparam int IDX_W  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int ENT_W  = 1 + KEY_W + PAY_W;

    logic [ENT_W-1:0]  r_mem [TABLE_SLOTS];

    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [PAY_W-1:0]  r_payload;
    logic [CNT_W-1:0]  r_issue_cnt;
    logic              r_chk_live;
    logic [IDX_W-1:0]  r_chk_idx;
    logic [ADDR_W-1:0] r_chk_addr;
    logic [ENT_W-1:0]  r_rd_ent;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_valid;
    logic              r_hit;
    logic [PAY_W-1:0]  r_found;
    logic [SLOT_W-1:0] r_slot;
    logic              r_evicted;

    logic [ADDR_W-1:0] home;
    logic [ADDR_W-1:0] probe_addr;
    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic [PAY_W-1:0]  rd_pay;
    logic              is_insert;
    logic              match;
    logic              evict;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;

    // home slot is the low key bits, probes wrap by address overflow
    assign home       = r_key[ADDR_W-1:0];
    assign probe_addr = home + ADDR_W'(r_issue_cnt);

    assign rd_valid = r_rd_ent[ENT_W-1];
    assign rd_key   = r_rd_ent[ENT_W-2 -: KEY_W];
    assign rd_pay   = r_rd_ent[PAY_W-1:0];

    assign is_insert = (r_op == OP_INSERT);
    assign match     = is_insert ? !rd_valid : (rd_valid && (rd_key == r_key));
    assign evict     = is_insert && !match;

    assign o_sts.chk_live   = r_chk_live;
    assign o_sts.chk_hit    = match;
    assign o_sts.chk_last   = (r_chk_idx == IDX_W'(PROBE_LIMIT - 1));
    assign o_sts.issue_more = (r_issue_cnt < CNT_W'(PROBE_LIMIT));
    assign o_sts.clr_done   = (r_clr_addr == ADDR_W'(TABLE_SLOTS - 1));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_chk_addr;
        wr_data = {1'b1, r_key, r_payload};
        if (i_cmd.clr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.finish && is_insert) begin
            wr_en   = 1'b1;
            wr_addr = evict ? home : r_chk_addr;
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.probe) begin
            r_rd_ent <= r_mem[probe_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_chk_live  <= 1'b0;
            r_issue_cnt <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid    <= i_cmd.finish;
            r_chk_live <= i_cmd.probe;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_issue_cnt <= '0;
            end else if (i_cmd.probe) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
            end
        end
    end

    // request, probe tracking and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_key     <= i_key;
            r_payload <= i_payload;
        end
        if (i_cmd.probe) begin
            r_chk_idx  <= IDX_W'(r_issue_cnt);
            r_chk_addr <= probe_addr;
        end
        if (i_cmd.finish) begin
            r_hit     <= !is_insert && match;
            r_found   <= (!is_insert && match) ? rd_pay : '0;
            r_evicted <= evict;
            if (evict) begin
                r_slot <= SLOT_W'(home);
            end else if (match) begin
                r_slot <= SLOT_W'(r_chk_addr);
            end else begin
                r_slot <= '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_found_payload = r_found;
    assign o_slot_used     = r_slot;
    assign o_evicted       = r_evicted;

endmodule

// File: hdl/probed_query_result_cache.sv
// ----------------------------------------------------------------------------
// probed_query_result_cache: key to result handle cache with linear probing
// direct-mapped table, bounded probe sequence, one result per request
// ----------------------------------------------------------------------------
// A request (lookup or insert) is taken when start is high and busy is low.
// Its result appears on the o_ ports for exactly one cycle, marked by
// o_valid, and cannot be held off. The slot memory has one read port, so the
// probes of a request are read one per cycle; busy stays high until the
// search ends and the result strobes in the cycle busy drops, so the next
// request can be taken only from then on. Lookup misses and evicting inserts
// always run the full probe sequence. After reset, busy stays high while a
// clearing pass invalidates every slot. TABLE_SLOTS must be a power of two;
// the home slot is the low key bits.
// ----------------------------------------------------------------------------
module probed_query_result_cache
    import qrc_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [PAY_W-1:0]  i_payload,
    output logic              o_valid,
    output logic              o_hit,
    output logic [PAY_W-1:0]  o_found_payload,
    output logic [SLOT_W-1:0] o_slot_used,
    output logic              o_evicted
);

    // sequencer commands and datapath status
    t_cmd cmd;
    t_sts sts;

    // controller: clearing pass, request capture, probe stepping
    qrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: slot memory, compare, result registers
    qrc_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_found_payload (o_found_payload),
        .o_slot_used     (o_slot_used),
        .o_evicted       (o_evicted)
    );

`ifndef SYNTH
    // an accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // results never come in consecutive cycles
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a hit and an eviction exclude each other
    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    // no handle without a hit
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_found_payload == '0))
        else $error("handle returned without a hit");
`endif

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the probed query result cache
// lookups and inserts go through the start/busy handshake; a slot-table model
// predicts each result and a scoreboard compares every strobed result field by
// field, under three sender idle profiles
// ----------------------------------------------------------------------------
module testbench;
    import qrc_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;  // clearing pass plus ~800 requests, many times over
    localparam int RANDOM_ITEMS  = 750;
    localparam int HOT_SPAN      = 12;       // homes in the crowded window
    localparam int KEEP_KEYS     = 48;       // inserted keys kept for lookups that should hit
    localparam int SETTLE_CYCLES = PROBE_LIMIT_DEF + 4;

    // one expected result of the cache
    typedef struct {
        logic              hit;
        logic [PAY_W-1:0]  found_payload;
        logic [SLOT_W-1:0] slot_used;
        logic              evicted;
    } t_cache_result;

    // slot table model and queue of results still owed by the block
    class t_probe_cache_predictor;
        bit                slot_live [TABLE_SLOTS_DEF];
        logic [KEY_W-1:0]  slot_key  [TABLE_SLOTS_DEF];
        logic [PAY_W-1:0]  slot_pay  [TABLE_SLOTS_DEF];
        t_cache_result     due_results[$];
        int failures, lookups, hits, inserts, evictions;

        // apply one accepted request to the table and queue its result
        function void take_request(logic op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
            t_cache_result res;
            int home, s, i;
            bit done;
            res  = '{hit: 1'b0, found_payload: '0, slot_used: '0, evicted: 1'b0};
            home = int'(key % 64'(TABLE_SLOTS_DEF));
            done = 1'b0;
            if (op == OP_LOOKUP) begin
                lookups++;
                for (i = 0; i < PROBE_LIMIT_DEF && !done; i++) begin
                    s = (home + i) % TABLE_SLOTS_DEF;
                    if (slot_live[s] && slot_key[s] == key) begin
                        res.hit           = 1'b1;
                        res.found_payload = slot_pay[s];
                        res.slot_used     = SLOT_W'(s);
                        done              = 1'b1;
                        hits++;
                    end
                end
            end else begin
                inserts++;
                for (i = 0; i < PROBE_LIMIT_DEF && !done; i++) begin
                    s = (home + i) % TABLE_SLOTS_DEF;
                    if (!slot_live[s]) begin
                        slot_live[s]  = 1'b1;
                        slot_key[s]   = key;
                        slot_pay[s]   = pay;
                        res.slot_used = SLOT_W'(s);
                        done          = 1'b1;
                    end
                end
                if (!done) begin
                    slot_live[home] = 1'b1;
                    slot_key[home]  = key;
                    slot_pay[home]  = pay;
                    res.slot_used   = SLOT_W'(home);
                    res.evicted     = 1'b1;
                    evictions++;
                end
            end
            due_results.push_back(res);
        endfunction

        // compare one strobed result with the oldest one owed
        function void check_result(logic hit, logic [PAY_W-1:0] found_payload,
                                   logic [SLOT_W-1:0] slot_used, logic evicted);
            t_cache_result exp_res;
            if (due_results.size() == 0) begin
                $error("result strobed with no request outstanding");
                failures++;
                return;
            end
            exp_res = due_results.pop_front();
            if (hit !== exp_res.hit) begin
                $error("hit: expected %0d, got %0d", exp_res.hit, hit);
                failures++;
            end
            if (found_payload !== exp_res.found_payload) begin
                $error("found_payload: expected %h, got %h", exp_res.found_payload, found_payload);
                failures++;
            end
            if (slot_used !== exp_res.slot_used) begin
                $error("slot_used: expected %0d, got %0d", exp_res.slot_used, slot_used);
                failures++;
            end
            if (evicted !== exp_res.evicted) begin
                $error("evicted: expected %0d, got %0d", exp_res.evicted, evicted);
                failures++;
            end
        endfunction

        function int owed();
            return due_results.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_operation = OP_LOOKUP;
    logic [KEY_W-1:0]  i_key = '0;
    logic [PAY_W-1:0]  i_payload = '0;
    logic              o_valid;
    logic              o_hit;
    logic [PAY_W-1:0]  o_found_payload;
    logic [SLOT_W-1:0] o_slot_used;
    logic              o_evicted;

    t_probe_cache_predictor cache_model = new();
    logic [KEY_W-1:0]     stored_keys[$];   // recent insert keys, source of hits
    int                   hot_base;         // first home of the crowded window
    int                   cycle_count = 0;

    probed_query_result_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_found_payload (o_found_payload),
        .o_slot_used     (o_slot_used),
        .o_evicted       (o_evicted)
    );

    always #10 i_clk = ~i_clk;

    // results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle; outputs are read before that edge updates them
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid === 1'b1)
            cache_model.check_result(o_hit, o_found_payload, o_slot_used, o_evicted);
    end

    // watchdog: the slowest legal run is far below this
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    // present one request and hold it until the edge where busy is low;
    // called at a rising edge, returns at the accepting edge
    task automatic issue_request(input logic op, input logic [KEY_W-1:0] key,
                                 input logic [PAY_W-1:0] pay);
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_payload   <= pay;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        cache_model.take_request(op, key, pay);
        if (op == OP_INSERT) begin
            stored_keys.push_back(key);
            if (stored_keys.size() > KEEP_KEYS) void'(stored_keys.pop_front());
        end
    endtask

    // sender idles cycle by cycle with the given chance in percent
    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold off until the block owes nothing
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (cache_model.owed() != 0) @(posedge i_clk);
    endtask

    // random upper bits over a home inside the crowded window, which sits
    // across the table wrap in the first phase so probes wrap to slot 0
    function automatic logic [KEY_W-1:0] crowded_key();
        logic [KEY_W-1:0] key;
        int home;
        home = (hot_base + $urandom_range(HOT_SPAN - 1)) % TABLE_SLOTS_DEF;
        key  = {$urandom, $urandom};
        key[SLOT_W-1:0] = SLOT_W'(home);
        return key;
    endfunction

    function automatic logic [KEY_W-1:0] recent_key();
        return stored_keys[$urandom_range(stored_keys.size() - 1)];
    endfunction

    // one random request: inserts crowd a few homes so the probe sequence
    // fills and evicts; most lookups use stored keys so hits are common
    task automatic random_request(input int idle_pct);
        logic [KEY_W-1:0] key;
        int pick;
        sender_gap(idle_pct);
        pick = $urandom_range(9);
        if ($urandom_range(99) < 45) begin
            if (stored_keys.size() != 0 && pick < 2)
                key = recent_key();          // duplicate key insert
            else if (pick < 4)
                key = {$urandom, $urandom};
            else
                key = crowded_key();
            issue_request(OP_INSERT, key, $urandom);
        end else begin
            if (stored_keys.size() != 0 && pick < 6)
                key = recent_key();
            else if (pick < 8)
                key = crowded_key();
            else
                key = {$urandom, $urandom};
            issue_request(OP_LOOKUP, key, $urandom);
        end
    endtask

    initial begin
        int phase, n;
        int idle_profile[3];
        idle_profile = '{24, 51, 0};
        hot_base = TABLE_SLOTS_DEF - 4;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; busy covers the clearing pass, so the first
        // request simply waits for it
        // lookups on an empty table, one at the last home so probes wrap
        issue_request(OP_LOOKUP, '0, '0);
        issue_request(OP_LOOKUP, '1, '1);
        // five keys on the last home: slots 4095, 0, 1, 2, then eviction
        issue_request(OP_INSERT, '1, '1);
        issue_request(OP_INSERT, 64'h0000_0000_0000_0FFF, 32'h0000_0001);
        issue_request(OP_INSERT, 64'h0000_0000_0000_1FFF, 32'h8000_0000);
        issue_request(OP_INSERT, 64'h8000_0000_0000_0FFF, 32'h5A5A_A5A5);
        issue_request(OP_INSERT, 64'h0000_0000_0000_2FFF, 32'hDEAD_BEEF);
        // hit after wrap, miss on the evicted key, hit on the new home owner
        issue_request(OP_LOOKUP, 64'h0000_0000_0000_0FFF, '0);
        issue_request(OP_LOOKUP, '1, '0);
        issue_request(OP_LOOKUP, 64'h0000_0000_0000_2FFF, '1);
        issue_request(OP_LOOKUP, 64'h8000_0000_0000_0FFF, '0);
        // key zero lands past the wrapped entries, payload zero
        issue_request(OP_INSERT, '0, '0);
        issue_request(OP_LOOKUP, '0, '1);
        // duplicate of a present key finds no free probe and evicts
        issue_request(OP_INSERT, 64'h0000_0000_0000_0FFF, 32'h0000_1234);
        issue_request(OP_LOOKUP, 64'h0000_0000_0000_0FFF, '0);
        // miss whose probes touch only free slots, payload ignored
        issue_request(OP_LOOKUP, 64'h0000_0000_0000_0005, '1);
        // same home, different upper bits: miss despite valid slots
        issue_request(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        drain_results();

        // random part in three idle profiles, drained between them
        for (phase = 0; phase < 3; phase++) begin
            if (phase != 0) hot_base = $urandom_range(TABLE_SLOTS_DEF - 1);
            for (n = 0; n < RANDOM_ITEMS / 3; n++)
                random_request(idle_profile[phase]);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (cache_model.owed() != 0) begin
            $error("%0d results never strobed", cache_model.owed());
            cache_model.failures++;
        end

        $display("run covered %0d lookups with %0d hits and %0d inserts with %0d evictions",
                 cache_model.lookups, cache_model.hits, cache_model.inserts,
                 cache_model.evictions);
        $display("sender idle profiles 24%%, 51%% and none; %0d cycles", cycle_count);
        if (cache_model.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
hdl/qrc_pkg.sv
hdl/qrc_ctrl.sv
hdl/qrc_datapath.sv
hdl/probed_query_result_cache.sv
bench/testbench.sv
